// ===== design/ico_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ico_pkg
// Shared types, codes and constants of the icosphere face subdivider.
// ---------------------------------------------------------------------------
package ico_pkg;

  localparam int COORD_FRAC_BITS = 14;
  localparam int RAW_W  = 18;
  localparam int IDX_W  = 12;
  localparam int POS_W  = 15;
  localparam int NRM_W  = 16;
  localparam int KEY_W  = 2 * IDX_W;
  localparam int SQ_W   = 2 * RAW_W;
  localparam int RAD_W  = SQ_W + 16;
  localparam int ROOT_W = RAD_W / 2;
  localparam int NUM_W  = RAW_W + COORD_FRAC_BITS + 8 + 1;
  localparam int QUO_W  = 16;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 144;

  typedef enum logic [1:0] {
    IN_VERTEX = 2'd0,
    IN_FACE   = 2'd1,
    IN_CLEAR  = 2'd2,
    IN_NONE   = 2'd3
  } in_kind_t;

  typedef enum logic [1:0] {
    RES_VERTEX = 2'd0,
    RES_FACE   = 2'd1,
    RES_ERROR  = 2'd2
  } res_kind_t;

  typedef enum logic [3:0] {
    C_IDLE, C_DISPATCH, C_ADD_WAIT, C_ADD_EMIT, C_EDGE_START, C_EDGE_RD, C_EDGE_CMP,
    C_NRD_A, C_NRD_B, C_NRD_C, C_MID_GO, C_MID_WAIT, C_MID_EMIT, C_FACE, C_ERROR
  } ctrl_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SQ, N_CHK, N_ROOT, N_DSET, N_DIV, N_DST, N_DONE
  } norm_state_t;

  typedef struct packed {
    logic      take_item;
    logic      clear;
    logic      norm_go;
    logic      norm_mid;
    logic      scan_clr;
    logic      scan_inc;
    logic      nrd_b;
    logic      cap_a;
    logic      cap_b;
    logic      mid_hit;
    logic      store_vtx;
    logic      add_edge;
    logic      emit;
    res_kind_t emit_kind;
    logic      emit_last;
    logic [1:0] edge_sel;
    logic [1:0] face_sel;
  } ico_cmd_t;

  typedef struct packed {
    in_kind_t kind;
    logic     corner_bad;
    logic     vfull;
    logic     efull;
    logic     ecount_zero;
    logic     scan_last;
    logic     key_hit;
    logic     norm_done;
    logic     norm_zero;
    logic     out_free;
  } ico_sts_t;

  // Half-scale position: magnitude halved, rounded half away from zero.
  function automatic logic signed [POS_W-1:0] half_pos(input logic signed [NRM_W-1:0] n);
    logic [NRM_W-1:0] mag;
    logic [NRM_W-1:0] h;
    mag = n[NRM_W-1] ? NRM_W'(-n) : NRM_W'(n);
    h   = (mag + NRM_W'(1)) >> 1;
    return n[NRM_W-1] ? POS_W'(-h) : POS_W'(h);
  endfunction

endpackage

// ===== design/ico_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ico_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ico_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/ico_norm.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ico_norm
// Iterative vector normalizer: sum of squares, bit-serial square root and
// one shared restoring divider for the three components.
// ---------------------------------------------------------------------------
module ico_norm
  import ico_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic signed [RAW_W-1:0] vx,
  input  logic signed [RAW_W-1:0] vy,
  input  logic signed [RAW_W-1:0] vz,
  output logic                    done,
  output logic                    zero,
  output logic signed [NRM_W-1:0] nx,
  output logic signed [NRM_W-1:0] ny,
  output logic signed [NRM_W-1:0] nz
);
  localparam logic [QUO_W-1:0] ONE = QUO_W'(1 << COORD_FRAC_BITS);

  norm_state_t       state;
  logic [2:0]        sgn;
  logic [RAW_W-1:0]  mag [3];
  logic [SQ_W-1:0]   acc;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W-1:0] root;
  logic [4:0]        cnt;
  logic [1:0]        comp;
  logic [NUM_W-1:0]  drem;
  logic [NUM_W-1:0]  dvs;
  logic [QUO_W-1:0]  quo;
  logic              sat;
  logic signed [NRM_W-1:0] nrm [3];

  logic [ROOT_W+2:0] remsh;
  logic [ROOT_W+2:0] trial;
  logic [NUM_W-1:0]  num;
  logic [QUO_W-1:0]  qsat;

  assign remsh = {rem, rad[RAD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign num   = NUM_W'({mag[comp], (COORD_FRAC_BITS + 8)'(0)}) + NUM_W'(root >> 1);
  assign qsat  = (sat || quo > ONE) ? ONE : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (go) begin
            sgn    <= {vz[RAW_W-1], vy[RAW_W-1], vx[RAW_W-1]};
            mag[0] <= vx[RAW_W-1] ? RAW_W'(-vx) : RAW_W'(vx);
            mag[1] <= vy[RAW_W-1] ? RAW_W'(-vy) : RAW_W'(vy);
            mag[2] <= vz[RAW_W-1] ? RAW_W'(-vz) : RAW_W'(vz);
            acc    <= '0;
            cnt    <= '0;
            state  <= N_SQ;
          end
        end
        N_SQ: begin
          acc <= acc + mag[cnt[1:0]] * mag[cnt[1:0]];
          cnt <= cnt + 5'd1;
          if (cnt == 5'd2) begin
            state <= N_CHK;
          end
        end
        N_CHK: begin
          zero <= (acc == '0);
          rad  <= {acc, 16'b0};
          rem  <= '0;
          root <= '0;
          cnt  <= '0;
          comp <= '0;
          state <= (acc == '0) ? N_DONE : N_ROOT;
        end
        N_ROOT: begin
          if (remsh >= trial) begin
            rem  <= (ROOT_W+1)'(remsh - trial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= (ROOT_W+1)'(remsh);
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          rad <= rad << 2;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(ROOT_W - 1)) begin
            state <= N_DSET;
          end
        end
        N_DSET: begin
          drem  <= num;
          dvs   <= NUM_W'({root, (QUO_W-1)'(0)});
          sat   <= ({1'b0, num} >= (NUM_W+1)'({root, QUO_W'(0)}));
          quo   <= '0;
          cnt   <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          if (drem >= dvs) begin
            drem <= drem - dvs;
            quo  <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            quo  <= {quo[QUO_W-2:0], 1'b0};
          end
          dvs <= dvs >> 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(QUO_W - 1)) begin
            state <= N_DST;
          end
        end
        N_DST: begin
          nrm[comp] <= sgn[comp] ? NRM_W'(-qsat) : NRM_W'(qsat);
          if (comp == 2'd2) begin
            state <= N_DONE;
          end else begin
            comp  <= comp + 2'd1;
            state <= N_DSET;
          end
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: begin
          state <= N_IDLE;
        end
      endcase
    end
  end

  assign done = (state == N_DONE);
  assign nx = nrm[0];
  assign ny = nrm[1];
  assign nz = nrm[2];

  ast_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("normalizer done held longer than one cycle");
endmodule

// ===== design/ico_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ico_ctrl
// Sequencer: dispatches requests, walks the edges of a face request and emits its sub-faces.
// ---------------------------------------------------------------------------
module ico_ctrl
  import ico_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  ico_sts_t sts,
  output ico_cmd_t cmd
);
  ctrl_state_t state, state_next;
  logic [1:0]  edge_sel, edge_sel_next;
  logic [1:0]  face_sel, face_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      edge_sel <= '0;
      face_sel <= '0;
    end else begin
      state    <= state_next;
      edge_sel <= edge_sel_next;
      face_sel <= face_sel_next;
    end
  end

  always_comb begin
    state_next    = state;
    edge_sel_next = edge_sel;
    face_sel_next = face_sel;
    cmd           = '0;
    cmd.edge_sel  = edge_sel;
    cmd.face_sel  = face_sel;
    s_tready      = 1'b0;
    unique case (state)
      C_IDLE: begin
        s_tready      = 1'b1;
        cmd.take_item = s_tvalid;
        if (s_tvalid) begin
          state_next = C_DISPATCH;
        end
      end
      C_DISPATCH: begin
        unique case (sts.kind)
          IN_VERTEX: begin
            if (sts.vfull) begin
              state_next = C_ERROR;
            end else begin
              cmd.norm_go = 1'b1;
              state_next  = C_ADD_WAIT;
            end
          end
          IN_FACE: begin
            edge_sel_next = '0;
            state_next    = sts.corner_bad ? C_ERROR : C_EDGE_START;
          end
          IN_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = C_IDLE;
          end
          default: begin
            state_next = C_IDLE;
          end
        endcase
      end
      C_ADD_WAIT: begin
        if (sts.norm_done) begin
          state_next = sts.norm_zero ? C_ERROR : C_ADD_EMIT;
        end
      end
      C_ADD_EMIT: begin
        if (sts.out_free) begin
          cmd.store_vtx = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = RES_VERTEX;
          cmd.emit_last = 1'b1;
          state_next    = C_IDLE;
        end
      end
      C_EDGE_START: begin
        cmd.scan_clr = 1'b1;
        state_next   = sts.ecount_zero ? C_NRD_A : C_EDGE_RD;
      end
      C_EDGE_RD: begin
        state_next = C_EDGE_CMP;
      end
      C_EDGE_CMP: begin
        if (sts.key_hit) begin
          cmd.mid_hit = 1'b1;
          if (edge_sel == 2'd2) begin
            face_sel_next = '0;
            state_next    = C_FACE;
          end else begin
            edge_sel_next = edge_sel + 2'd1;
            state_next    = C_EDGE_START;
          end
        end else if (sts.scan_last) begin
          state_next = C_NRD_A;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = C_EDGE_RD;
        end
      end
      C_NRD_A: begin
        state_next = C_NRD_B;
      end
      C_NRD_B: begin
        cmd.nrd_b  = 1'b1;
        cmd.cap_a  = 1'b1;
        state_next = C_NRD_C;
      end
      C_NRD_C: begin
        cmd.cap_b  = 1'b1;
        state_next = C_MID_GO;
      end
      C_MID_GO: begin
        cmd.norm_go  = 1'b1;
        cmd.norm_mid = 1'b1;
        state_next   = C_MID_WAIT;
      end
      C_MID_WAIT: begin
        if (sts.norm_done) begin
          if (sts.norm_zero || sts.vfull || sts.efull) begin
            state_next = C_ERROR;
          end else begin
            state_next = C_MID_EMIT;
          end
        end
      end
      C_MID_EMIT: begin
        if (sts.out_free) begin
          cmd.store_vtx = 1'b1;
          cmd.add_edge  = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = RES_VERTEX;
          if (edge_sel == 2'd2) begin
            face_sel_next = '0;
            state_next    = C_FACE;
          end else begin
            edge_sel_next = edge_sel + 2'd1;
            state_next    = C_EDGE_START;
          end
        end
      end
      C_FACE: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RES_FACE;
          cmd.emit_last = (face_sel == 2'd3);
          face_sel_next = face_sel + 2'd1;
          if (face_sel == 2'd3) begin
            state_next = C_IDLE;
          end
        end
      end
      C_ERROR: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RES_ERROR;
          cmd.emit_last = 1'b1;
          state_next    = C_IDLE;
        end
      end
      default: begin
        state_next = C_IDLE;
      end
    endcase
  end
endmodule

// ===== design/ico_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ico_dp
// Datapath: request register, counts, vertex and edge stores, normalizer,
// result register.
// ---------------------------------------------------------------------------
module ico_dp
  import ico_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  input  ico_cmd_t              cmd,
  output ico_sts_t              sts,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser,
  output logic                  m_tlast
);
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int NV_W = 3 * NRM_W;

  in_kind_t                kind;
  logic signed [RAW_W-1:0] raw [3];
  logic [IDX_W-1:0]        corner [3];
  logic [VCW-1:0]          vcount;
  logic [ECW-1:0]          ecount;
  logic [ECW-1:0]          scan;
  logic [IDX_W-1:0]        mid [3];
  logic [NV_W-1:0]         na;
  logic [NV_W-1:0]         nb;

  logic [IDX_W-1:0]        ea, eb, lo, hi;
  logic [KEY_W-1:0]        key;
  logic [NV_W-1:0]         nrm_rdata;
  logic [KEY_W+IDX_W-1:0]  edge_rdata;
  logic signed [RAW_W-1:0] vin [3];
  logic                    norm_done, norm_zero;
  logic signed [NRM_W-1:0] nx, ny, nz;
  logic                    out_free;
  logic [OUT_DATA_W-1:0]   data_next;

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      kind      <= in_kind_t'(s_tuser);
      raw[0]    <= s_tdata[0 +: RAW_W];
      raw[1]    <= s_tdata[RAW_W +: RAW_W];
      raw[2]    <= s_tdata[2*RAW_W +: RAW_W];
      corner[0] <= s_tdata[3*RAW_W +: IDX_W];
      corner[1] <= s_tdata[3*RAW_W+IDX_W +: IDX_W];
      corner[2] <= s_tdata[3*RAW_W+2*IDX_W +: IDX_W];
    end
  end

  always_comb begin
    case (cmd.edge_sel)
      2'd0:    begin ea = corner[0]; eb = corner[1]; end
      2'd1:    begin ea = corner[1]; eb = corner[2]; end
      default: begin ea = corner[2]; eb = corner[0]; end
    endcase
    lo  = (ea < eb) ? ea : eb;
    hi  = (ea < eb) ? eb : ea;
    key = {lo, hi};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
      ecount <= '0;
    end else if (cmd.clear) begin
      vcount <= '0;
      ecount <= '0;
    end else begin
      if (cmd.store_vtx) begin
        vcount <= vcount + VCW'(1);
      end
      if (cmd.add_edge) begin
        ecount <= ecount + ECW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + ECW'(1);
    end
    if (cmd.cap_a) begin
      na <= nrm_rdata;
    end
    if (cmd.cap_b) begin
      nb <= nrm_rdata;
    end
    if (cmd.mid_hit) begin
      mid[cmd.edge_sel] <= edge_rdata[KEY_W +: IDX_W];
    end else if (cmd.add_edge) begin
      mid[cmd.edge_sel] <= IDX_W'(vcount);
    end
  end

  ico_ram #(.WIDTH(NV_W), .DEPTH(MAX_VERTICES)) u_nrm_ram (
    .clk   (clk),
    .we    (cmd.store_vtx),
    .waddr (vcount[VAW-1:0]),
    .wdata ({nz, ny, nx}),
    .raddr (VAW'(cmd.nrd_b ? eb : ea)),
    .rdata (nrm_rdata)
  );

  ico_ram #(.WIDTH(KEY_W + IDX_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (cmd.add_edge),
    .waddr (ecount[EAW-1:0]),
    .wdata ({IDX_W'(vcount), key}),
    .raddr (scan[EAW-1:0]),
    .rdata (edge_rdata)
  );

  // For a midpoint the direction is the sum of the two stored normals; otherwise it is the raw request vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.norm_mid) begin
        vin[i] = RAW_W'($signed(na[i*NRM_W +: NRM_W])) + RAW_W'($signed(nb[i*NRM_W +: NRM_W]));
      end else begin
        vin[i] = raw[i];
      end
    end
  end

  ico_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.norm_go),
    .vx   (vin[0]),
    .vy   (vin[1]),
    .vz   (vin[2]),
    .done (norm_done),
    .zero (norm_zero),
    .nx   (nx),
    .ny   (ny),
    .nz   (nz)
  );

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    sts             = '0;
    sts.kind        = kind;
    sts.corner_bad  = (32'(corner[0]) >= 32'(vcount)) || (32'(corner[1]) >= 32'(vcount))
                   || (32'(corner[2]) >= 32'(vcount));
    sts.vfull       = (vcount == VCW'(MAX_VERTICES));
    sts.efull       = (ecount == ECW'(MAX_EDGES));
    sts.ecount_zero = (ecount == '0);
    sts.scan_last   = (scan == ecount - ECW'(1));
    sts.key_hit     = (edge_rdata[KEY_W-1:0] == key);
    sts.norm_done   = norm_done;
    sts.norm_zero   = norm_zero;
    sts.out_free    = out_free;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    data_next = '0;
    case (cmd.emit_kind)
      RES_VERTEX: begin
        data_next[0 +: IDX_W]                     = IDX_W'(vcount);
        data_next[IDX_W +: POS_W]                 = half_pos(nx);
        data_next[IDX_W+POS_W +: POS_W]           = half_pos(ny);
        data_next[IDX_W+2*POS_W +: POS_W]         = half_pos(nz);
        data_next[IDX_W+3*POS_W +: NRM_W]         = nx;
        data_next[IDX_W+3*POS_W+NRM_W +: NRM_W]   = ny;
        data_next[IDX_W+3*POS_W+2*NRM_W +: NRM_W] = nz;
      end
      RES_FACE: begin
        case (cmd.face_sel)
          2'd0:    data_next[IDX_W+3*POS_W+3*NRM_W +: 3*IDX_W] = {mid[2], mid[0], corner[0]};
          2'd1:    data_next[IDX_W+3*POS_W+3*NRM_W +: 3*IDX_W] = {mid[0], mid[1], corner[1]};
          2'd2:    data_next[IDX_W+3*POS_W+3*NRM_W +: 3*IDX_W] = {mid[1], mid[2], corner[2]};
          default: data_next[IDX_W+3*POS_W+3*NRM_W +: 3*IDX_W] = {mid[2], mid[1], mid[0]};
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tuser <= cmd.emit_kind;
      m_tlast <= cmd.emit_last;
      m_tdata <= data_next;
    end
  end

  ast_emit_free: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> out_free)
    else $error("result loaded over an unaccepted result");
  ast_edge_vertex: assert property (@(posedge clk) disable iff (rst)
    cmd.add_edge |-> cmd.store_vtx && !sts.vfull && !sts.efull)
    else $error("edge stored without a fresh midpoint vertex");
  ast_vcount_bound: assert property (@(posedge clk) disable iff (rst)
    32'(vcount) <= MAX_VERTICES && 32'(ecount) <= MAX_EDGES)
    else $error("store count beyond capacity");
endmodule

// ===== design/icosphere_face_subdivider.sv =====
`timescale 1ns / 1ps
// An add-vertex request runs the shared normalizer: 3 square steps, 26 square-root steps and
//   three divides, one per component, before its result is emitted.
// A face request: a dispatch step, then per edge a scan of the stored edges and, on a
//   midpoint miss, a normalization; then the four faces. Clear is done at dispatch.
// One request at a time; the result register lets the next request in while results wait.
// Reset (rst, synchronous) empties the vertex and edge stores at once by zeroing the counts.
// ---------------------------------------------------------------------------
// icosphere_face_subdivider
// Icosphere subdivision engine: vertex normalization, edge midpoint cache
// and four-way face split, as a controller plus datapath.
// ---------------------------------------------------------------------------
module icosphere_face_subdivider
  import ico_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata from bit 0: raw_x, raw_y, raw_z, corner_one, corner_two, corner_three, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // tuser: kind
  input  logic [1:0]            s_tuser,
  // result channel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata from bit 0: vertex_index, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
  // face_a, face_b, face_c, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  // tuser: result_kind
  output logic [1:0]            m_tuser,
  output logic                  m_tlast
);
  ico_cmd_t cmd;
  ico_sts_t sts;

  // Sequencer: owns the request handshake and walks edges and faces.
  ico_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: stores, normalizer and the result register.
  ico_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );
endmodule

// ===== bench/icosphere_face_subdivider_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// icosphere_face_subdivider_tb
// Self-checking bench: drives add, subdivide, clear and unused-kind requests through the
// stream ports and checks every result against a predictor of the mesh engine.
// ---------------------------------------------------------------------------
module icosphere_face_subdivider_tb;
  import ico_pkg::*;

  localparam int VTX_CAP  = 4096;
  localparam int EDGE_CAP = 4096;
  localparam int ONE_Q14  = 1 << COORD_FRAC_BITS;
  localparam int PHI_Q14  = 26509;

  typedef struct {
    res_kind_t   kind;
    logic [11:0] idx;
    logic [14:0] px, py, pz;
    logic [15:0] nx, ny, nz;
    logic [11:0] fa, fb, fc;
    logic        last;
  } mesh_result_t;

  // Integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Project a vector onto the unit sphere; returns 0 on zero length.
  function automatic bit unit_vec(input longint v[3], output int n[3]);
    longint unsigned mag[3];
    longint unsigned s, r, q;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
      s += mag[i] * mag[i];
    end
    if (s == 0) return 0;
    if (s < (64'd1 << 46)) r = int_sqrt(s << 16);
    else r = int_sqrt(s) << 8;
    if (r == 0) return 0;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << (COORD_FRAC_BITS + 8)) + r / 2) / r;
      if (q > ONE_Q14) q = ONE_Q14;
      n[i] = v[i] < 0 ? -int'(q) : int'(q);
    end
    return 1;
  endfunction

  class mesh_scoreboard;
    int           normals[VTX_CAP][3];
    int           vcount;
    int           ecount;
    int           edge_mid[int];
    int           faces[$][3];
    mesh_result_t expected[$];
    int           errors;

    function void clear_all();
      vcount = 0;
      ecount = 0;
      edge_mid.delete();
      faces.delete();
    endfunction

    function mesh_result_t blank(res_kind_t k);
      mesh_result_t r;
      r = '{kind: k, default: 0};
      return r;
    endfunction

    function mesh_result_t vertex_res(int idx, int n[3]);
      mesh_result_t r;
      int a, h;
      int hp[3];
      r = blank(RES_VERTEX);
      r.idx = 12'(idx);
      for (int i = 0; i < 3; i++) begin
        a = n[i] < 0 ? -n[i] : n[i];
        h = (a + 1) >> 1;
        hp[i] = n[i] < 0 ? -h : h;
      end
      r.px = 15'(hp[0]); r.py = 15'(hp[1]); r.pz = 15'(hp[2]);
      r.nx = 16'(n[0]); r.ny = 16'(n[1]); r.nz = 16'(n[2]);
      return r;
    endfunction

    function mesh_result_t face_res(int a, int b, int c);
      mesh_result_t r;
      r = blank(RES_FACE);
      r.fa = 12'(a); r.fb = 12'(b); r.fc = 12'(c);
      if (faces.size() < 2000) faces.insert(faces.size(), '{a, b, c});
      return r;
    endfunction

    function int store(int n[3]);
      for (int i = 0; i < 3; i++) normals[vcount][i] = n[i];
      vcount++;
      return vcount - 1;
    endfunction

    // Note an accepted request and queue the results it must cause.
    function void note(in_kind_t k, logic [IN_DATA_W-1:0] d);
      mesh_result_t out[$];
      longint v[3];
      int n[3];
      int c[3], mid[3];
      int a, b, lo, hi, key;
      bit bad;
      bad = 0;
      if (k == IN_CLEAR) begin
        clear_all();
        return;
      end
      if (k == IN_NONE) return;
      if (k == IN_VERTEX) begin
        v[0] = longint'($signed(d[17:0]));
        v[1] = longint'($signed(d[35:18]));
        v[2] = longint'($signed(d[53:36]));
        if (vcount >= VTX_CAP || !unit_vec(v, n)) bad = 1;
        else out.insert(out.size(), vertex_res(store(n), n));
      end else begin
        c[0] = int'(d[65:54]); c[1] = int'(d[77:66]); c[2] = int'(d[89:78]);
        for (int i = 0; i < 3; i++) if (c[i] >= vcount) bad = 1;
        for (int e = 0; e < 3 && !bad; e++) begin
          a = c[e];
          b = c[(e + 1) % 3];
          lo = a < b ? a : b;
          hi = a < b ? b : a;
          key = lo * 4096 + hi;
          if (edge_mid.exists(key)) begin
            mid[e] = edge_mid[key];
          end else begin
            for (int i = 0; i < 3; i++) v[i] = longint'(normals[a][i]) + normals[b][i];
            if (!unit_vec(v, n) || vcount >= VTX_CAP || ecount >= EDGE_CAP) begin
              bad = 1;
            end else begin
              mid[e] = store(n);
              edge_mid[key] = mid[e];
              ecount++;
              out.insert(out.size(), vertex_res(mid[e], n));
            end
          end
        end
        if (!bad) begin
          out.insert(out.size(), face_res(c[0], mid[0], mid[2]));
          out.insert(out.size(), face_res(c[1], mid[1], mid[0]));
          out.insert(out.size(), face_res(c[2], mid[2], mid[1]));
          out.insert(out.size(), face_res(mid[0], mid[1], mid[2]));
        end
      end
      if (bad) out.insert(out.size(), blank(RES_ERROR));
      out[out.size() - 1].last = 1;
      foreach (out[i]) expected.insert(expected.size(), out[i]);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    // Check one accepted result against the oldest expectation.
    function void check(mesh_result_t got);
      mesh_result_t e;
      if (expected.size() == 0) begin
        $error("unexpected result, kind %0d", got.kind);
        errors++;
        return;
      end
      e = expected.pop_front();
      cmp("result_kind", e.kind, got.kind);
      cmp("vertex_index", e.idx, got.idx);
      cmp("pos_x", e.px, got.px);
      cmp("pos_y", e.py, got.py);
      cmp("pos_z", e.pz, got.pz);
      cmp("normal_x", e.nx, got.nx);
      cmp("normal_y", e.ny, got.ny);
      cmp("normal_z", e.nz, got.nz);
      cmp("face_a", e.fa, got.fa);
      cmp("face_b", e.fb, got.fb);
      cmp("face_c", e.fc, got.fc);
      cmp("last", e.last, got.last);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // tdata from bit 0: raw_x, raw_y, raw_z, corner_one, corner_two, corner_three, zero pad
  logic [IN_DATA_W-1:0]  s_tdata;
  // tuser: kind
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  // tdata from bit 0: vertex_index, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
  // face_a, face_b, face_c, zero pad
  logic [OUT_DATA_W-1:0] m_tdata;
  // tuser: result_kind
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  mesh_scoreboard sb;
  int             burst_left;
  int             rx_hold;
  int             rx_cycle;

  icosphere_face_subdivider dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Offer one request; note it in the scoreboard at the accepting edge.
  // Bursts of random length keep valid high, random gaps drop it between them.
  task automatic send(in_kind_t k, logic [IN_DATA_W-1:0] d);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note(k, d);
    burst_left--;
  endtask

  task automatic add_point(int x, int y, int z);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[17:0] = 18'(x); d[35:18] = 18'(y); d[53:36] = 18'(z);
    send(IN_VERTEX, d);
  endtask

  task automatic split_face(int a, int b, int c);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[65:54] = 12'(a); d[77:66] = 12'(b); d[89:78] = 12'(c);
    send(IN_FACE, d);
  endtask

  // Random 18-bit coordinate: sometimes full range, sometimes small.
  function automatic int rand_coord();
    if ($urandom_range(0, 1)) return $signed(18'($urandom()));
    return int'($urandom_range(0, 64)) - 32;
  endfunction

  // Feed the twelve icosahedron corners and its twenty faces.
  task automatic seed_icosahedron();
    int seed_faces[20][3] = '{
      '{0, 11, 5}, '{0, 5, 1}, '{0, 1, 7}, '{0, 7, 10}, '{0, 10, 11},
      '{1, 5, 9}, '{5, 11, 4}, '{11, 10, 2}, '{10, 7, 6}, '{7, 1, 8},
      '{3, 9, 4}, '{3, 4, 2}, '{3, 2, 6}, '{3, 6, 8}, '{3, 8, 9},
      '{4, 9, 5}, '{2, 4, 11}, '{6, 2, 10}, '{8, 6, 7}, '{9, 8, 1}};
    for (int s = -1; s <= 1; s += 2) begin
      add_point(-ONE_Q14, s * PHI_Q14, 0);
      add_point(ONE_Q14, s * PHI_Q14, 0);
    end
    for (int s = -1; s <= 1; s += 2) begin
      add_point(0, -ONE_Q14, s * PHI_Q14);
      add_point(0, ONE_Q14, s * PHI_Q14);
    end
    for (int s = -1; s <= 1; s += 2) begin
      add_point(PHI_Q14, 0, s * ONE_Q14);
      add_point(-PHI_Q14, 0, s * ONE_Q14);
    end
    for (int i = 0; i < 20; i++)
      split_face(seed_faces[i][0], seed_faces[i][1], seed_faces[i][2]);
  endtask

  // Receiver: alternate fully ready stretches with random stalls; one long
  // hold lets the result register fill and back-pressure the request side.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_cycle <= 0;
      rx_hold  <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle == 3000) begin
        rx_hold  <= 600;
        m_tready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold  <= rx_hold - 1;
        m_tready <= 1'b0;
      end else if ((rx_cycle / 64) % 3 == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  // Check each accepted result.
  always @(posedge clk) begin
    mesh_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = res_kind_t'(m_tuser);
      got.idx  = m_tdata[11:0];
      got.px   = m_tdata[26:12];
      got.py   = m_tdata[41:27];
      got.pz   = m_tdata[56:42];
      got.nx   = m_tdata[72:57];
      got.ny   = m_tdata[88:73];
      got.nz   = m_tdata[104:89];
      got.fa   = m_tdata[116:105];
      got.fb   = m_tdata[128:117];
      got.fc   = m_tdata[140:129];
      got.last = m_tlast;
      sb.check(got);
    end
  end

  // Hard stop for a hung block.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int pick, a, b;
    logic [IN_DATA_W-1:0] noise;
    sb = new();
    sb.clear_all();
    burst_left = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = IN_NONE;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, unused kind, zero length, antipodes, repeats.
    send(IN_CLEAR, '0);
    send(IN_NONE, '1);
    add_point(0, 0, 0);
    add_point(-131072, -131072, -131072);
    add_point(131071, 131071, 131071);
    add_point(ONE_Q14, 0, 0);
    add_point(-ONE_Q14, 0, 0);
    add_point(0, 1, 0);
    add_point(131071, -131072, -5);
    split_face(2, 3, 2);
    split_face(0, 4, 5);
    split_face(5, 4, 0);
    split_face(4, 4, 5);
    split_face(0, 1, 4095);
    split_face(4095, 0, 0);
    send(IN_NONE, '0);
    split_face(1, 5, 0);

    // Random: seed the solid, then subdivide its faces with noise mixed in.
    for (int round = 0; round < 2; round++) begin
      send(IN_CLEAR, '0);
      seed_icosahedron();
      for (int i = 0; i < 58; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70 && sb.faces.size() > 0) begin
          a = $urandom_range(0, sb.faces.size() - 1);
          split_face(sb.faces[a][0], sb.faces[a][1], sb.faces[a][2]);
        end else if (pick < 80) begin
          add_point(rand_coord(), rand_coord(), rand_coord());
        end else if (pick < 88) begin
          if ($urandom_range(0, 1))
            split_face($urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095));
          else
            split_face($urandom_range(0, sb.vcount - 1), $urandom_range(0, sb.vcount - 1),
                       $urandom_range(0, sb.vcount - 1));
        end else if (pick < 94) begin
          b = $urandom_range(0, sb.vcount - 1);
          split_face(b, b, $urandom_range(0, sb.vcount - 1));
        end else begin
          noise = {$urandom(), $urandom(), $urandom()};
          send(IN_NONE, noise);
        end
      end
    end

    // Tail: clear, a few fresh points and faces over them.
    send(IN_CLEAR, '0);
    add_point(ONE_Q14, ONE_Q14, 0);
    add_point(-131072, 131071, 7);
    add_point(0, ONE_Q14, ONE_Q14);
    split_face(0, 1, 2);
    split_face(2, 1, 0);
    send(IN_CLEAR, '0);
    add_point(0, 0, -ONE_Q14);
    s_tvalid <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
